>>> design/csvp_pkg.sv
package csvp_pkg;

  // Characters are compared in their low CHAR_BITS bits.
  localparam int CHAR_BITS = 16;
  localparam int CHAR_W = 16;
  localparam logic [CHAR_W-1:0] CHAR_MASK =
      (CHAR_BITS >= CHAR_W) ? {CHAR_W{1'b1}} : CHAR_W'((64'd1 << CHAR_BITS) - 64'd1);

  localparam logic [CHAR_W-1:0] QUOTE_CHAR = 16'd34;
  localparam logic [CHAR_W-1:0] CR_CHAR = 16'd13;

  // Result bundle depth: most results one item can cause.
  localparam int MAX_RES = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_RECORD_END = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MORE = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [1:0] REG_SEPARATOR = 2'd0;
  localparam logic [1:0] REG_LINE_BREAK = 2'd1;
  localparam logic [1:0] REG_BREAK_CR = 2'd2;

  localparam logic [CHAR_W-1:0] SEPARATOR_RESET = 16'd44;
  localparam logic [CHAR_W-1:0] LINE_BREAK_RESET = 16'd10;

  typedef struct packed {
    logic              action;
    logic [CHAR_W-1:0] char_code;
  } in_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CHAR_W-1:0] char_out;
    logic [1:0]        status;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CHAR_W-1:0] char_out;
    logic [1:0]        status;
  } res_t;

  typedef struct packed {
    logic [2:0]              count;
    res_t [MAX_RES-1:0]      res;
  } bundle_t;

  typedef struct packed {
    logic [CHAR_W-1:0] separator;
    logic [CHAR_W-1:0] line_break_char;
    logic              break_with_cr;
  } cfg_t;

  function automatic res_t make_res(logic [1:0] kind, logic [CHAR_W-1:0] ch,
                                    logic [1:0] status);
    res_t r;
    r.kind = kind;
    r.char_out = (kind == KIND_DATA) ? ch : '0;
    r.status = (kind == KIND_RECORD_END) ? status : ST_OK;
    return r;
  endfunction

endpackage

>>> design/csvp_front.sv
module csvp_front (
  input  logic              clk,
  input  logic              rst,
  input  csvp_pkg::in_t     in_data,
  input  logic              accept,
  input  csvp_pkg::cfg_t    cfg,
  output csvp_pkg::bundle_t bundle
);

  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_UNQUOTED = 3'd1;
  localparam logic [2:0] MODE_QUOTED = 3'd2;
  localparam logic [2:0] MODE_QSEEN = 3'd3;
  localparam logic [2:0] MODE_ERROR = 3'd4;

  logic [2:0] parse_mode, parse_mode_next;
  logic       record_started, record_started_next;
  logic       break_pending, break_pending_next;

  logic [csvp_pkg::CHAR_W-1:0] c;
  logic                        is_quote, is_sep;

  assign c = in_data.char_code & csvp_pkg::CHAR_MASK;
  assign is_quote = c == (csvp_pkg::QUOTE_CHAR & csvp_pkg::CHAR_MASK);
  assign is_sep = c == (cfg.separator & csvp_pkg::CHAR_MASK);

  always_comb begin
    logic [2:0] n;
    n = '0;
    bundle = '0;
    parse_mode_next = parse_mode;
    record_started_next = record_started;
    break_pending_next = break_pending;

    // Line break owed from a record that ended inside quotes.
    if (break_pending) begin
      if (cfg.break_with_cr) begin
        bundle.res[n[1:0]] = csvp_pkg::make_res(csvp_pkg::KIND_DATA, csvp_pkg::CR_CHAR,
                                                csvp_pkg::ST_OK);
        n = n + 3'd1;
      end
      bundle.res[n[1:0]] = csvp_pkg::make_res(csvp_pkg::KIND_DATA, cfg.line_break_char,
                                              csvp_pkg::ST_OK);
      n = n + 3'd1;
      break_pending_next = 1'b0;
    end

    if (in_data.action) begin
      case (parse_mode)
        MODE_START, MODE_UNQUOTED, MODE_QSEEN: begin
          if (parse_mode != MODE_START || record_started) begin
            bundle.res[n[1:0]] = csvp_pkg::make_res(csvp_pkg::KIND_FIELD_END, '0,
                                                    csvp_pkg::ST_OK);
            n = n + 3'd1;
          end
          bundle.res[n[1:0]] = csvp_pkg::make_res(csvp_pkg::KIND_RECORD_END, '0,
                                                  csvp_pkg::ST_OK);
          n = n + 3'd1;
          parse_mode_next = MODE_START;
          record_started_next = 1'b0;
          break_pending_next = 1'b0;
        end
        MODE_QUOTED: begin
          bundle.res[n[1:0]] = csvp_pkg::make_res(csvp_pkg::KIND_RECORD_END, '0,
                                                  csvp_pkg::ST_MORE);
          n = n + 3'd1;
          break_pending_next = 1'b1;
          record_started_next = 1'b1;
        end
        default: begin
          bundle.res[n[1:0]] = csvp_pkg::make_res(csvp_pkg::KIND_RECORD_END, '0,
                                                  csvp_pkg::ST_ERROR);
          n = n + 3'd1;
          parse_mode_next = MODE_START;
          record_started_next = 1'b0;
          break_pending_next = 1'b0;
        end
      endcase
    end else begin
      record_started_next = 1'b1;
      case (parse_mode)
        MODE_START: begin
          if (is_quote) begin
            parse_mode_next = MODE_QUOTED;
          end else if (is_sep) begin
            bundle.res[n[1:0]] = csvp_pkg::make_res(csvp_pkg::KIND_FIELD_END, '0,
                                                    csvp_pkg::ST_OK);
            n = n + 3'd1;
          end else begin
            bundle.res[n[1:0]] = csvp_pkg::make_res(csvp_pkg::KIND_DATA, c,
                                                    csvp_pkg::ST_OK);
            n = n + 3'd1;
            parse_mode_next = MODE_UNQUOTED;
          end
        end
        MODE_UNQUOTED: begin
          if (is_sep) begin
            bundle.res[n[1:0]] = csvp_pkg::make_res(csvp_pkg::KIND_FIELD_END, '0,
                                                    csvp_pkg::ST_OK);
            n = n + 3'd1;
            parse_mode_next = MODE_START;
          end else if (is_quote) begin
            parse_mode_next = MODE_ERROR;
          end else begin
            bundle.res[n[1:0]] = csvp_pkg::make_res(csvp_pkg::KIND_DATA, c,
                                                    csvp_pkg::ST_OK);
            n = n + 3'd1;
          end
        end
        MODE_QUOTED: begin
          if (is_quote) begin
            parse_mode_next = MODE_QSEEN;
          end else begin
            bundle.res[n[1:0]] = csvp_pkg::make_res(csvp_pkg::KIND_DATA, c,
                                                    csvp_pkg::ST_OK);
            n = n + 3'd1;
          end
        end
        MODE_QSEEN: begin
          if (is_quote) begin
            bundle.res[n[1:0]] = csvp_pkg::make_res(csvp_pkg::KIND_DATA,
                                                    csvp_pkg::QUOTE_CHAR, csvp_pkg::ST_OK);
            n = n + 3'd1;
            parse_mode_next = MODE_QUOTED;
          end else if (is_sep) begin
            bundle.res[n[1:0]] = csvp_pkg::make_res(csvp_pkg::KIND_FIELD_END, '0,
                                                    csvp_pkg::ST_OK);
            n = n + 3'd1;
            parse_mode_next = MODE_START;
          end else begin
            parse_mode_next = MODE_ERROR;
          end
        end
        default: begin
          parse_mode_next = MODE_ERROR;
        end
      endcase
    end
    bundle.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode <= MODE_START;
      record_started <= 1'b0;
      break_pending <= 1'b0;
    end else if (accept) begin
      parse_mode <= parse_mode_next;
      record_started <= record_started_next;
      break_pending <= break_pending_next;
    end
  end

endmodule

>>> design/csvp_queue.sv
module csvp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  csvp_pkg::bundle_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output csvp_pkg::bundle_t head
);

  localparam int PTR_W = $clog2(csvp_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(csvp_pkg::QUEUE_DEPTH + 1);

  csvp_pkg::bundle_t    entries [csvp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [CNT_W-1:0]     fill;

  assign full = fill == CNT_W'(csvp_pkg::QUEUE_DEPTH);
  assign empty = fill == '0;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> design/csvp_back.sv
module csvp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  csvp_pkg::bundle_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output csvp_pkg::out_t    out_data
);

  logic [1:0] idx;
  logic       is_last;

  assign is_last = {1'b0, idx} == (head.count - 3'd1);
  assign out_valid = !empty;
  assign out_data.kind = head.res[idx].kind;
  assign out_data.char_out = head.res[idx].char_out;
  assign out_data.status = head.res[idx].status;
  assign out_data.last = is_last;
  assign pop = out_valid && !out_stall && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (out_valid && !out_stall) begin
      idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

>>> design/csv_record_parser_top.sv
// Channel  Direction  Payload              Handshake
// in       input      csvp_pkg::in_t       in_valid / in_stall
// out      output     csvp_pkg::out_t      out_valid / out_stall
// cfg      input      cfg_index, cfg_data  cfg_write (no wait, no read-back)
//
// One input beat is taken every cycle while the result queue has room; the
// front parser decides all results of an item in that one cycle.
// Results leave one beat per cycle while out_stall is low, so an item that causes several results
// uses as many output beats; the four-entry bundle queue absorbs the burst.
// rst is synchronous: it clears parser state, empties the queue and loads
// the register defaults (comma separator, newline break, no CR).
// in_stall rises only when the queue is full; out_stall holds the current beat.
module csv_record_parser_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  csvp_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output csvp_pkg::out_t              out_data,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [csvp_pkg::CHAR_W-1:0] cfg_data
);

  csvp_pkg::cfg_t    cfg;
  csvp_pkg::bundle_t bundle;
  csvp_pkg::bundle_t head;
  logic              accept;
  logic              push;
  logic              pop;
  logic              full;
  logic              empty;

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.separator <= csvp_pkg::SEPARATOR_RESET;
      cfg.line_break_char <= csvp_pkg::LINE_BREAK_RESET;
      cfg.break_with_cr <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        csvp_pkg::REG_SEPARATOR:  cfg.separator <= cfg_data;
        csvp_pkg::REG_LINE_BREAK: cfg.line_break_char <= cfg_data;
        csvp_pkg::REG_BREAK_CR:   cfg.break_with_cr <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stall input only when no bundle slot is free.
  assign in_stall = full;
  assign accept = in_valid && !full;
  // Drop items that cause no result (an opening quote, swallowed error text).
  assign push = accept && (bundle.count != 3'd0);

  csvp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_data(in_data),
    .accept (accept),
    .cfg    (cfg),
    .bundle (bundle)
  );

  csvp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(bundle),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  csvp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

>>> dv/csv_tb_pkg.sv
`timescale 1ns / 100ps

package csv_tb_pkg;
  import csvp_pkg::*;

  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_EOL  = 1'b1;

  typedef enum logic [2:0] {
    PM_START,
    PM_UNQUOTED,
    PM_QUOTED,
    PM_QSEEN,
    PM_ERROR
  } parse_mode_e;

  class csv_scoreboard;
    logic [CHAR_W-1:0] sep;
    logic [CHAR_W-1:0] line_break;
    logic              break_cr;
    parse_mode_e       mode;
    bit                started;
    bit                break_pending;
    out_t              expected_tokens[$];
    int                n_errors;
    int                beats_in;
    int                beats_out;
    int                rec_status[3];

    function new();
      sep = SEPARATOR_RESET;
      line_break = LINE_BREAK_RESET;
      break_cr = 1'b0;
      clear_record();
    endfunction

    function void clear_record();
      mode = PM_START;
      started = 0;
      break_pending = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CHAR_W-1:0] val);
      case (idx)
        REG_SEPARATOR:  sep = val;
        REG_LINE_BREAK: line_break = val;
        REG_BREAK_CR:   break_cr = val[0];
        default: ;
      endcase
    endfunction

    function out_t token(logic [1:0] kind, logic [CHAR_W-1:0] ch, logic [1:0] status);
      out_t t;
      t.kind = kind;
      t.char_out = ch;
      t.status = status;
      t.last = 1'b0;
      return t;
    endfunction

    // Append one token at the tail of a token list.
    function void append_tok(ref out_t q[$], input out_t t);
      q.insert(q.size(), t);
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    // Work out the tokens one accepted character or end-of-line beat produces.
    function void parse_beat(in_t beat);
      logic [CHAR_W-1:0] c, sep_m, quote_m;
      out_t burst[$];
      c = beat.char_code & CHAR_MASK;
      sep_m = sep & CHAR_MASK;
      quote_m = QUOTE_CHAR & CHAR_MASK;
      beats_in++;
      // A line that ended inside quotes continues: emit the break first.
      if (break_pending) begin
        if (break_cr) append_tok(burst, token(KIND_DATA, CR_CHAR, ST_OK));
        append_tok(burst, token(KIND_DATA, line_break, ST_OK));
        break_pending = 0;
      end
      if (beat.action == ACT_EOL) begin
        case (mode)
          PM_START: begin
            if (started) append_tok(burst, token(KIND_FIELD_END, '0, ST_OK));
            append_tok(burst, token(KIND_RECORD_END, '0, ST_OK));
            clear_record();
          end
          PM_UNQUOTED, PM_QSEEN: begin
            append_tok(burst, token(KIND_FIELD_END, '0, ST_OK));
            append_tok(burst, token(KIND_RECORD_END, '0, ST_OK));
            clear_record();
          end
          PM_QUOTED: begin
            append_tok(burst, token(KIND_RECORD_END, '0, ST_MORE));
            break_pending = 1;
            started = 1;
          end
          default: begin
            append_tok(burst, token(KIND_RECORD_END, '0, ST_ERROR));
            clear_record();
          end
        endcase
      end else begin
        started = 1;
        case (mode)
          PM_START: begin
            if (c == quote_m) begin
              mode = PM_QUOTED;
            end else if (c == sep_m) begin
              append_tok(burst, token(KIND_FIELD_END, '0, ST_OK));
            end else begin
              append_tok(burst, token(KIND_DATA, c, ST_OK));
              mode = PM_UNQUOTED;
            end
          end
          PM_UNQUOTED: begin
            if (c == sep_m) begin
              append_tok(burst, token(KIND_FIELD_END, '0, ST_OK));
              mode = PM_START;
            end else if (c == quote_m) begin
              mode = PM_ERROR;
            end else begin
              append_tok(burst, token(KIND_DATA, c, ST_OK));
            end
          end
          PM_QUOTED: begin
            if (c == quote_m) mode = PM_QSEEN;
            else append_tok(burst, token(KIND_DATA, c, ST_OK));
          end
          PM_QSEEN: begin
            if (c == quote_m) begin
              append_tok(burst, token(KIND_DATA, QUOTE_CHAR, ST_OK));
              mode = PM_QUOTED;
            end else if (c == sep_m) begin
              append_tok(burst, token(KIND_FIELD_END, '0, ST_OK));
              mode = PM_START;
            end else begin
              mode = PM_ERROR;
            end
          end
          default: mode = PM_ERROR;
        endcase
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) append_tok(expected_tokens, burst[i]);
    endfunction

    function void check_token(out_t got);
      out_t want;
      beats_out++;
      if (expected_tokens.size() == 0) begin
        $error("unexpected token: kind %0d char_out %h status %0d last %0b",
               got.kind, got.char_out, got.status, got.last);
        n_errors++;
        return;
      end
      want = expected_tokens.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        n_errors++;
      end
      if (got.char_out !== want.char_out) begin
        $error("char_out: expected %h, actual %h", want.char_out, got.char_out);
        n_errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        n_errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        n_errors++;
      end
      if (want.kind == KIND_RECORD_END) rec_status[want.status]++;
    endfunction
  endclass

endpackage

>>> dv/csv_record_parser_top_test.sv
`timescale 1ns / 100ps

module csv_record_parser_top_test;
  import csvp_pkg::*;
  import csv_tb_pkg::*;

  localparam int LONG_HOLD   = 300;   // receiver hold-off, long enough to fill the queue
  localparam int SETTLE      = 8;     // cycles to let a zero-token item finish
  localparam int QUIET_LIMIT = 5000;  // watchdog: cycles with no beat on either side
  localparam int PHASE_ITEMS = 60;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  in_t               in_data = '0;
  logic              out_stall = 1'b0;
  logic              cfg_write = 1'b0;
  logic [1:0]        cfg_index = REG_SEPARATOR;
  logic [CHAR_W-1:0] cfg_data = '0;
  logic              in_stall;
  logic              out_valid;
  out_t              out_data;

  csv_scoreboard     sb;
  in_t               stim_q[$];
  logic [CHAR_W-1:0] cur_sep = SEPARATOR_RESET;
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                hold_requests = 0;
  int                hold_served = 0;
  int                quiet_cycles = 0;
  int                n_settings = 1;

  csv_record_parser_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver: stall at random per cycle, or hold off for a long stretch on
  // request. The stretch is counted here so the sender keeps running.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_served) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Monitor both channels at the edge, where handshake values are the ones
  // that held during the cycle. Also run the no-progress watchdog here.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.parse_beat(in_data);
      if (out_valid && !out_stall) sb.check_token(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $error("no progress for %0d cycles, %0d tokens still expected",
               QUIET_LIMIT, sb.pending());
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Append one beat at the tail of the stimulus list.
  function automatic void queue_beat(in_t b);
    stim_q.insert(stim_q.size(), b);
  endfunction

  function automatic void push_char(logic [CHAR_W-1:0] c);
    in_t b;
    b.action = ACT_CHAR;
    b.char_code = c;
    queue_beat(b);
  endfunction

  // The char_code of an end-of-line beat is ignored; randomize it anyway.
  function automatic void push_eol();
    in_t b;
    b.action = ACT_EOL;
    b.char_code = CHAR_W'($urandom_range(0, 65535));
    queue_beat(b);
  endfunction

  // Any character that is neither the quote nor the current separator.
  function automatic logic [CHAR_W-1:0] plain_char();
    logic [CHAR_W-1:0] c;
    do begin
      if ($urandom_range(9) < 2) c = CHAR_W'($urandom_range(0, 65535));
      else c = CHAR_W'($urandom_range(32'h61, 32'h7a));
    end while (c == QUOTE_CHAR || c == cur_sep);
    return c;
  endfunction

  // Append one line: mostly a well-formed record of plain and quoted fields,
  // sometimes a line of raw noise built from the characters that matter.
  function automatic void gen_record();
    int nf;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(5))
          0: push_char(QUOTE_CHAR);
          1: push_char(cur_sep);
          2: push_eol();
          default: push_char(plain_char());
        endcase
      end
      push_eol();
      return;
    end
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) push_char(cur_sep);
      if ($urandom_range(99) < 55) begin
        repeat ($urandom_range(0, 4)) push_char(plain_char());
      end else begin
        push_char(QUOTE_CHAR);
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(9))
            0: push_char(cur_sep);
            1: begin
              push_char(QUOTE_CHAR);
              push_char(QUOTE_CHAR);
            end
            2: push_eol();  // line ends inside quotes: record continues
            default: push_char(plain_char());
          endcase
        end
        push_char(QUOTE_CHAR);
      end
    end
    if ($urandom_range(9) == 0) push_char(cur_sep);
    push_eol();
  endfunction

  // Wait for every expected token, then let a zero-token item settle.
  // Never returns without waiting on the clock.
  task automatic wait_drained();
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all three registers on back-to-back cycles; the block is idle.
  task automatic write_regs(input logic [CHAR_W-1:0] sep,
                            input logic [CHAR_W-1:0] lb,
                            input logic cr);
    cfg_write <= 1'b1;
    cfg_index <= REG_SEPARATOR;
    cfg_data  <= sep;
    @(posedge clk);
    cfg_index <= REG_LINE_BREAK;
    cfg_data  <= lb;
    @(posedge clk);
    cfg_index <= REG_BREAK_CR;
    cfg_data  <= CHAR_W'(cr);
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(REG_SEPARATOR, sep);
    sb.set_reg(REG_LINE_BREAK, lb);
    sb.set_reg(REG_BREAK_CR, CHAR_W'(cr));
    cur_sep = sep;
    n_settings++;
  endtask

  // Offer the queued beats in order. Valid stays high across back-to-back
  // beats; random idle gaps lower it. Optionally pause halfway until the
  // block has delivered everything.
  task automatic send_stim(input bit pause_midway);
    for (int i = 0; i < stim_q.size(); i++) begin
      if (pause_midway && i == stim_q.size() / 2) begin
        in_valid <= 1'b0;
        wait_drained();
      end else if ($urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < idle_pct);
      end
      in_valid <= 1'b1;
      in_data  <= stim_q[i];
      do @(posedge clk); while (!(in_valid && !in_stall));
    end
    in_valid <= 1'b0;
    stim_q.delete();
  endtask

  task automatic run_phase(input logic [CHAR_W-1:0] sep, input logic [CHAR_W-1:0] lb,
                           input logic cr, input int in_idle, input int out_stall_pct,
                           input bit long_hold, input bit pause_midway);
    write_regs(sep, lb, cr);
    idle_pct = in_idle;
    stall_pct = out_stall_pct;
    while (stim_q.size() < PHASE_ITEMS) gen_record();
    if (long_hold) hold_requests++;
    send_stim(pause_midway);
    wait_drained();
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed lines at the reset settings (comma, newline, no CR).
    push_eol();                               // empty line: bare record end
    push_char(16'hFFFF);                      // all-ones character
    push_char(SEPARATOR_RESET);
    push_eol();                               // trailing separator: empty field
    push_char(QUOTE_CHAR);
    push_char(16'h0078);
    push_char(QUOTE_CHAR);
    push_char(QUOTE_CHAR);                    // doubled quote inside quotes
    push_char(QUOTE_CHAR);                    // closing quote
    push_char(SEPARATOR_RESET);
    push_eol();                               // trailing separator after quoted field
    push_char(16'h0061);
    push_char(QUOTE_CHAR);                    // quote in unquoted field: error
    push_char(16'h007A);                      // swallowed in error mode
    push_eol();
    push_char(QUOTE_CHAR);
    push_char(16'h0000);                      // all-zeros character
    push_char(QUOTE_CHAR);
    push_char(16'h0063);                      // bad closing quote
    push_eol();
    push_char(QUOTE_CHAR);
    push_eol();                               // ends inside quotes: need more
    push_eol();                               // empty continuation line
    push_char(16'h0072);
    push_char(QUOTE_CHAR);
    push_eol();
    send_stim(1'b0);
    wait_drained();

    // Random phases: sweep the registers through their extremes and the
    // separator-equals-quote corner while idling patterns change.
    run_phase(SEPARATOR_RESET, LINE_BREAK_RESET, 1'b1, 0, 0, 1'b1, 1'b0);
    run_phase(16'hFFFF, 16'h0000, 1'b0, 76, 0, 1'b0, 1'b0);
    run_phase(16'h0000, 16'hFFFF, 1'b1, 0, 76, 1'b0, 1'b0);
    run_phase(QUOTE_CHAR, CR_CHAR, 1'b0, 15, 15, 1'b0, 1'b0);
    run_phase(16'h0009, LINE_BREAK_RESET, 1'b1, 0, 0, 1'b0, 1'b1);

    $display("Summary: %0d input beats, %0d token beats checked over %0d register settings",
             sb.beats_in, sb.beats_out, n_settings);
    $display("Summary: record ends ok %0d, need-more %0d, error %0d",
             sb.rec_status[ST_OK], sb.rec_status[ST_MORE], sb.rec_status[ST_ERROR]);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
